@@ rtl/core/compact_host_placement_core_macros.svh @@
// assertion macros for the placement core
// a module that uses them has i_clk and i_rst_n
`ifndef COMPACT_HOST_PLACEMENT_CORE_MACROS_SVH
`define COMPACT_HOST_PLACEMENT_CORE_MACROS_SVH

`ifndef SYNTHESIS
`define CHP_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define CHP_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define CHP_ASSERT_IMP(lbl, ante, cons, msg)
`define CHP_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

@@ rtl/core/chp_pkg.sv @@
`timescale 1ns / 1ps
package chp_pkg;

    localparam int KEY_W = 32;
    localparam int CNT_W = 8;
    localparam int IDX_IN_W = 4;

    // output item kinds
    localparam logic [1:0] KIND_PLACE = 2'd0;
    localparam logic [1:0] KIND_FAIL  = 2'd1;
    localparam logic [1:0] KIND_EMPTY = 2'd2;

    // result status codes
    localparam logic ST_OK    = 1'b0;
    localparam logic ST_SHORT = 1'b1;

    // request types
    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_PLACE = 1'b1;

    typedef struct packed {
        logic             req_type;
        logic [IDX_IN_W-1:0] entry_index;
        logic             entry_valid;
        logic [KEY_W-1:0] host_key;
        logic [CNT_W-1:0] free_slots;
        logic [CNT_W-1:0] total_slots;
        logic [CNT_W-1:0] app_count;
        logic [CNT_W-1:0] msg_count;
        logic             app_first;
    } t_req;

    typedef struct packed {
        logic             status;
        logic [KEY_W-1:0] out_host_key;
        logic [CNT_W-1:0] placed_count;
        logic             last;
    } t_res;

    // field order gives the ranking order, largest first
    typedef struct packed {
        logic [CNT_W-1:0] app;
        logic [CNT_W-1:0] free;
        logic [CNT_W-1:0] total;
        logic [KEY_W-1:0] key;
    } t_host;

    typedef struct packed {
        logic       wr_entry;
        logic       start_place;
        logic       scan_start;
        logic       scan_sum;
        logic       commit;
        logic       load_out;
        logic [1:0] out_kind;
    } t_cmd;

    typedef struct packed {
        logic req_place;
        logic msg_zero;
        logic scan_busy;
        logic scan_done;
        logic sum_short;
        logic best_found;
        logic take_zero;
        logic take_last;
        logic out_free;
    } t_sts;

endpackage

@@ rtl/core/chp_stream_if.sv @@
`timescale 1ns / 1ps
interface chp_stream_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

@@ rtl/core/compact_host_placement_core.sv @@
`timescale 1ns / 1ps
// table write: writes the entry if its index is in range, no result
// place beat: a free-slot sum scan, then one selection scan per host taken or skipped
// and one result loaded per host taken; results wait while the output holds a beat; a short
// pool gives a fail result after the sum scan, an empty request an empty result, then the
// next beat is taken
// synchronous active-low reset clears the present marks, the controller and the output
module compact_host_placement_core #(
    parameter int MAX_HOSTS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    chp_stream_if.sink   i_req,
    chp_stream_if.source o_res
);
    chp_pkg::t_cmd w_cmd;
    chp_pkg::t_sts w_sts;

    chp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (i_req.ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    chp_datapath #(
        .MAX_HOSTS (MAX_HOSTS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_pl    (i_req.payload),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_out_ready (o_res.ready),
        .o_out_valid (o_res.valid),
        .o_out_pl    (o_res.payload)
    );
endmodule

@@ rtl/core/chp_ram.sv @@
`timescale 1ns / 1ps
module chp_ram #(
    parameter int WIDTH = 56,
    parameter int DEPTH = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

@@ rtl/core/chp_datapath.sv @@
`timescale 1ns / 1ps
`include "compact_host_placement_core_macros.svh"
module chp_datapath #(
    parameter int MAX_HOSTS = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  chp_pkg::t_req i_req_pl,
    input  chp_pkg::t_cmd i_cmd,
    output chp_pkg::t_sts o_sts,
    input  logic          i_out_ready,
    output logic          o_out_valid,
    output chp_pkg::t_res o_out_pl
);
    localparam int IW = (MAX_HOSTS > 1) ? $clog2(MAX_HOSTS) : 1;
    localparam int SW = $clog2(MAX_HOSTS * 255 + 1);
    localparam int HW = $bits(chp_pkg::t_host);

    logic [MAX_HOSTS-1:0]        r_present;
    logic [MAX_HOSTS-1:0]        r_used;
    logic [chp_pkg::CNT_W-1:0]   r_left;
    logic                        r_by_app;
    logic                        r_scan_on;
    logic                        r_scan_sum;
    logic [IW-1:0]               r_scan_addr;
    logic                        r_rd_vld;
    logic                        r_rd_last;
    logic [IW-1:0]               r_rd_idx;
    logic                        r_scan_done;
    logic [SW-1:0]               r_sum;
    logic                        r_best_found;
    logic [IW-1:0]               r_best_idx;
    chp_pkg::t_host              r_best;
    logic                        r_out_vld;
    chp_pkg::t_res               r_out_pl;

    logic                        w_wr_ok;
    logic [IW-1:0]               w_waddr;
    chp_pkg::t_host              w_wdata;
    chp_pkg::t_host              w_rdata;
    chp_pkg::t_host              w_cand;
    logic                        w_addr_last;
    logic                        w_hit;
    logic                        w_ahead;
    logic [chp_pkg::CNT_W-1:0]   w_take;
    chp_pkg::t_res               n_out_pl;

    assign w_wr_ok = i_cmd.wr_entry && (32'(i_req_pl.entry_index) < 32'(MAX_HOSTS));
    assign w_waddr = IW'(i_req_pl.entry_index);
    assign w_wdata = '{app:   i_req_pl.app_count,
                       free:  i_req_pl.free_slots,
                       total: i_req_pl.total_slots,
                       key:   i_req_pl.host_key};

    chp_ram #(
        .WIDTH (HW),
        .DEPTH (MAX_HOSTS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_wr_ok),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (r_scan_addr),
        .o_rdata (w_rdata)
    );

    assign w_addr_last = (r_scan_addr == IW'(MAX_HOSTS - 1));
    assign w_hit       = r_rd_vld && r_present[r_rd_idx];
    assign w_cand      = '{app:   r_by_app ? w_rdata.app : '0,
                           free:  w_rdata.free,
                           total: w_rdata.total,
                           key:   w_rdata.key};
    assign w_ahead     = !r_best_found || (w_cand > r_best);
    assign w_take      = (r_best.free >= r_left) ? r_left : r_best.free;

    always_comb begin
        case (i_cmd.out_kind)
            chp_pkg::KIND_PLACE: n_out_pl = '{status: chp_pkg::ST_OK,
                                              out_host_key: r_best.key,
                                              placed_count: w_take,
                                              last: (r_best.free >= r_left)};
            chp_pkg::KIND_FAIL:  n_out_pl = '{status: chp_pkg::ST_SHORT,
                                              out_host_key: '0,
                                              placed_count: '0,
                                              last: 1'b1};
            default:             n_out_pl = '{status: chp_pkg::ST_OK,
                                              out_host_key: '0,
                                              placed_count: '0,
                                              last: 1'b1};
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_present    <= '0;
            r_used       <= '0;
            r_scan_on    <= 1'b0;
            r_rd_vld     <= 1'b0;
            r_rd_last    <= 1'b0;
            r_scan_done  <= 1'b0;
            r_best_found <= 1'b0;
            r_out_vld    <= 1'b0;
        end else begin
            if (w_wr_ok) begin
                r_present[w_waddr] <= i_req_pl.entry_valid;
            end
            if (i_cmd.start_place) begin
                r_used <= '0;
            end
            if (i_cmd.commit) begin
                r_used[r_best_idx] <= 1'b1;
            end
            if (i_cmd.scan_start) begin
                r_scan_on <= 1'b1;
            end else if (r_scan_on && w_addr_last) begin
                r_scan_on <= 1'b0;
            end
            r_rd_vld    <= r_scan_on;
            r_rd_last   <= r_scan_on && w_addr_last;
            r_scan_done <= r_rd_vld && r_rd_last;
            if (i_cmd.scan_start && !i_cmd.scan_sum) begin
                r_best_found <= 1'b0;
            end else if (w_hit && !r_scan_sum && !r_used[r_rd_idx] && w_ahead) begin
                r_best_found <= 1'b1;
            end
            if (i_cmd.load_out) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.start_place) begin
            r_left   <= i_req_pl.msg_count;
            r_by_app <= i_req_pl.app_first;
        end else if (i_cmd.commit) begin
            r_left <= r_left - w_take;
        end
        if (i_cmd.scan_start) begin
            r_scan_addr <= '0;
            r_scan_sum  <= i_cmd.scan_sum;
        end else if (r_scan_on && !w_addr_last) begin
            r_scan_addr <= r_scan_addr + 1'b1;
        end
        r_rd_idx <= r_scan_addr;
        if (i_cmd.scan_start && i_cmd.scan_sum) begin
            r_sum <= '0;
        end else if (w_hit && r_scan_sum) begin
            r_sum <= r_sum + SW'(w_rdata.free);
        end
        if (w_hit && !r_scan_sum && !r_used[r_rd_idx] && w_ahead) begin
            r_best     <= w_cand;
            r_best_idx <= r_rd_idx;
        end
        if (i_cmd.load_out) begin
            r_out_pl <= n_out_pl;
        end
    end

    assign o_sts = '{req_place:  (i_req_pl.req_type == chp_pkg::REQ_PLACE),
                     msg_zero:   (i_req_pl.msg_count == '0),
                     scan_busy:  r_scan_on || r_rd_vld,
                     scan_done:  r_scan_done,
                     sum_short:  (r_sum < SW'(r_left)),
                     best_found: r_best_found,
                     take_zero:  (r_best.free == '0),
                     take_last:  (r_best.free >= r_left),
                     out_free:   !r_out_vld || i_out_ready};

    assign o_out_valid = r_out_vld;
    assign o_out_pl    = r_out_pl;

    `CHP_ASSERT_IMP(a_place_has_host,
        i_cmd.load_out && (i_cmd.out_kind == chp_pkg::KIND_PLACE),
        r_best_found && (r_best.free != '0),
        "placement beat without a host that has free slots")
    `CHP_ASSERT_IMP(a_rd_follows_scan, r_rd_vld, $past(r_scan_on),
        "table read data without a scan address")
    `CHP_ASSERT_NXT(a_commit_marks_used, i_cmd.commit, r_used[$past(r_best_idx)],
        "committed host not marked used")
endmodule

@@ rtl/core/chp_ctrl.sv @@
`timescale 1ns / 1ps
`include "compact_host_placement_core_macros.svh"
module chp_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  chp_pkg::t_sts i_sts,
    output chp_pkg::t_cmd o_cmd
);
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SUM   = 3'd1;
    localparam logic [2:0] S_SEL   = 3'd2;
    localparam logic [2:0] S_EMIT  = 3'd3;
    localparam logic [2:0] S_FAIL  = 3'd4;
    localparam logic [2:0] S_EMPTY = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        o_cmd.out_kind = chp_pkg::KIND_PLACE;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (!i_sts.req_place) begin
                        o_cmd.wr_entry = 1'b1;
                    end else begin
                        o_cmd.start_place = 1'b1;
                        if (i_sts.msg_zero) begin
                            n_state = S_EMPTY;
                        end else begin
                            o_cmd.scan_start = 1'b1;
                            o_cmd.scan_sum   = 1'b1;
                            n_state          = S_SUM;
                        end
                    end
                end
            end
            S_SUM: begin
                if (i_sts.scan_done) begin
                    if (i_sts.sum_short) begin
                        n_state = S_FAIL;
                    end else begin
                        o_cmd.scan_start = 1'b1;
                        n_state          = S_SEL;
                    end
                end
            end
            S_SEL: begin
                if (i_sts.scan_done) begin
                    if (!i_sts.best_found) begin
                        n_state = S_FAIL;
                    end else if (i_sts.take_zero) begin
                        // full host, skip it
                        o_cmd.commit     = 1'b1;
                        o_cmd.scan_start = 1'b1;
                    end else begin
                        n_state = S_EMIT;
                    end
                end
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.commit   = 1'b1;
                    o_cmd.load_out = 1'b1;
                    if (i_sts.take_last) begin
                        n_state = S_IDLE;
                    end else begin
                        o_cmd.scan_start = 1'b1;
                        n_state          = S_SEL;
                    end
                end
            end
            S_FAIL: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    o_cmd.out_kind = chp_pkg::KIND_FAIL;
                    n_state        = S_IDLE;
                end
            end
            S_EMPTY: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    o_cmd.out_kind = chp_pkg::KIND_EMPTY;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    `CHP_ASSERT_IMP(a_load_needs_room, o_cmd.load_out, i_sts.out_free,
        "result beat loaded over a waiting beat")
    `CHP_ASSERT_IMP(a_scan_not_busy, o_cmd.scan_start, !i_sts.scan_busy,
        "scan started while a scan is running")
endmodule
